@@ sv/hmt_pkg.sv @@
`timescale 1ns / 1ps

package hmt_pkg;

   localparam int BIN_COUNT_DEF  = 256;
   localparam int COUNT_BITS_DEF = 20;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int PASS_W  = 13;
   localparam int LIMIT_W = 12;
   localparam logic [LIMIT_W-1:0] PASS_LIMIT_RESET = 12'd1000;

   typedef enum logic [1:0] {
      STATUS_VALLEY   = 2'd0,
      STATUS_MIDPOINT = 2'd1,
      STATUS_SINGLE   = 2'd2,
      STATUS_NONE     = 2'd3
   } status_type;

   typedef struct packed {
      logic              clear;
      logic              acc_take;
      logic              acc_write;
      logic              stream_start;
      logic              stream_smooth;
      logic              src_bank;
      logic              rsp_load;
      status_type        rsp_status;
      logic [PASS_W-1:0] rsp_passes;
      logic              rsp_limit;
   } hmt_cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic       stream_done;
      logic       rsp_free;
      logic [1:0] levels;
      logic [1:0] peaks;
      logic       valley_found;
   } hmt_stat_type;

endpackage

@@ sv/hmt_ram.sv @@
`timescale 1ns / 1ps

module hmt_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ sv/hmt_ctrl.sv @@
`timescale 1ns / 1ps

module hmt_ctrl
   import hmt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   output logic               req_tready,
   input  logic               csr_valid,
   input  logic [LIMIT_W-1:0] csr_data,
   output logic               csr_ready,
   output hmt_cmd_type        cmd,
   input  hmt_stat_type       stat
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_ACC    = 8'b0000_0010,
      ST_ACC_WR = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_SCAN   = 8'b0001_0000,
      ST_SMOOTH = 8'b0010_0000,
      ST_VALLEY = 8'b0100_0000,
      ST_RESULT = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic               cur_ff, cur_in;
   logic [PASS_W-1:0]  passes_ff, passes_in;
   logic [PASS_W-1:0]  passes_next;
   logic               limit_ff, limit_in;
   status_type         status_ff, status_in;
   logic               start_ff, start_in;
   logic               smooth_ff, smooth_in;
   logic               last_ff, last_in;
   logic [LIMIT_W-1:0] max_ff, max_in;

   assign csr_ready   = 1'b1;
   assign req_tready  = (state_ff == ST_ACC);
   assign passes_next = passes_ff + 1'b1;

   always_comb begin
      cmd.clear         = (state_ff == ST_CLEAR);
      cmd.acc_take      = (state_ff == ST_ACC) && req_tvalid;
      cmd.acc_write     = (state_ff == ST_ACC_WR);
      cmd.stream_start  = start_ff;
      cmd.stream_smooth = smooth_ff;
      cmd.src_bank      = cur_ff;
      cmd.rsp_load      = (state_ff == ST_RESULT) && stat.rsp_free;
      cmd.rsp_status    = status_ff;
      cmd.rsp_passes    = passes_ff;
      cmd.rsp_limit     = limit_ff;
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      passes_in = passes_ff;
      limit_in  = limit_ff;
      status_in = status_ff;
      start_in  = 1'b0;
      smooth_in = smooth_ff;
      last_in   = last_ff;
      max_in    = csr_valid ? csr_data : max_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cur_in = 1'b0;
            if (stat.clear_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (req_tvalid) begin
               last_in  = req_tlast;
               state_in = ST_ACC_WR;
            end
         end
         ST_ACC_WR: begin
            state_in = last_ff ? ST_DECIDE : ST_ACC;
         end
         ST_DECIDE: begin
            passes_in = '0;
            limit_in  = 1'b0;
            priority if (stat.levels <= 2'd1) begin
               status_in = STATUS_SINGLE;
               state_in  = ST_RESULT;
            end else if (stat.levels == 2'd2) begin
               status_in = STATUS_MIDPOINT;
               state_in  = ST_RESULT;
            end else begin
               start_in  = 1'b1;
               smooth_in = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.stream_done) begin
               start_in = 1'b1;
               if (stat.peaks == 2'd2) begin
                  smooth_in = 1'b0;
                  state_in  = ST_VALLEY;
               end else begin
                  smooth_in = 1'b1;
                  state_in  = ST_SMOOTH;
               end
            end
         end
         ST_SMOOTH: begin
            if (stat.stream_done) begin
               passes_in = passes_next;
               start_in  = 1'b1;
               // over the limit: drop this pass and search the previous histogram
               priority if (passes_next > {1'b0, max_ff}) begin
                  limit_in  = 1'b1;
                  smooth_in = 1'b0;
                  state_in  = ST_VALLEY;
               end else if (stat.peaks == 2'd2) begin
                  cur_in    = ~cur_ff;
                  smooth_in = 1'b0;
                  state_in  = ST_VALLEY;
               end else begin
                  cur_in    = ~cur_ff;
                  smooth_in = 1'b1;
               end
            end
         end
         ST_VALLEY: begin
            if (stat.stream_done) begin
               status_in = stat.valley_found ? STATUS_VALLEY : STATUS_NONE;
               state_in  = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (stat.rsp_free) begin
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cur_ff    <= 1'b0;
         passes_ff <= '0;
         limit_ff  <= 1'b0;
         status_ff <= STATUS_SINGLE;
         start_ff  <= 1'b0;
         smooth_ff <= 1'b0;
         last_ff   <= 1'b0;
         max_ff    <= PASS_LIMIT_RESET;
      end else begin
         state_ff  <= state_in;
         cur_ff    <= cur_in;
         passes_ff <= passes_in;
         limit_ff  <= limit_in;
         status_ff <= status_in;
         start_ff  <= start_in;
         smooth_ff <= smooth_in;
         last_ff   <= last_in;
         max_ff    <= max_in;
      end
   end

`ifndef ASSERT_OFF
   a_smooth_within_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SMOOTH |-> passes_ff <= {1'b0, max_ff})
      else $error("smoothing continued past the pass limit");

   a_start_in_stream_state: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == ST_SCAN || state_ff == ST_SMOOTH || state_ff == ST_VALLEY))
      else $error("stream started outside a scan state");

   a_state_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
`endif

endmodule

@@ sv/hmt_datapath.sv @@
`timescale 1ns / 1ps

module hmt_datapath
   import hmt_pkg::*;
#(
   parameter int BIN_COUNT  = BIN_COUNT_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  hmt_cmd_type  cmd,
   output hmt_stat_type stat,
   input  logic [7:0]   req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,
   output logic [2:0]   rsp_tuser
);

   localparam int IDX_W      = $clog2(BIN_COUNT);
   localparam int BIN_W      = COUNT_BITS + FRAC_BITS;
   localparam int SUM_W      = BIN_W + 2;
   localparam int DIV_STAGES = (SUM_W + 15) / 16;
   localparam int PAD_W      = DIV_STAGES * 16;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_COUNT - 1);
   localparam logic [BIN_W-1:0] ONE_COUNT =
      {{(COUNT_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [BIN_W-1:0] MAX_BIN = {{COUNT_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

   // eight radix-4 steps of a divide by three, most significant digit first
   function automatic logic [17:0] div3_slice(input logic [1:0] rem_in,
                                              input logic [15:0] bits);
      logic [3:0]  v;
      logic [1:0]  qd;
      logic [1:0]  rem;
      logic [15:0] q;
      rem = rem_in;
      q   = '0;
      for (int i = 0; i < 8; i++) begin
         v = {rem, bits[15-2*i -: 2]};
         if (v >= 4'd9) begin
            qd = 2'd3;
         end else if (v >= 4'd6) begin
            qd = 2'd2;
         end else if (v >= 4'd3) begin
            qd = 2'd1;
         end else begin
            qd = 2'd0;
         end
         rem = 2'(v - ({2'b00, qd} + {1'b0, qd, 1'b0}));
         q[15-2*i -: 2] = qd;
      end
      return {rem, q};
   endfunction

   // banks
   logic             wr_en   [2];
   logic [IDX_W-1:0] wr_addr [2];
   logic [BIN_W-1:0] wr_data [2];
   logic [BIN_W-1:0] rd_data [2];
   logic [IDX_W-1:0] rd_addr;
   logic [BIN_W-1:0] rdata;

   // accumulation
   logic [IDX_W+7:0] req_wide;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] px_idx_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [1:0]       levels_ff;
   logic [IDX_W-1:0] lo_ff, hi_ff;
   logic [BIN_W-1:0] acc_val;

   // stream read side
   logic             running_ff;
   logic             smooth_mode_ff;
   logic [IDX_W:0]   rd_idx_ff;
   logic [IDX_W-1:0] stream_addr;
   logic             s1_v_ff;
   logic [IDX_W:0]   s1_idx_ff;
   logic [IDX_W:0]   s1_idx_m1;
   logic [BIN_W-1:0] win_pp_ff, win_p_ff;
   logic [SUM_W-1:0] win_sum;

   // divide pipeline
   logic             dv_ff   [DIV_STAGES+1];
   logic [IDX_W-1:0] didx_ff [DIV_STAGES+1];
   logic [PAD_W-1:0] dx_ff   [DIV_STAGES+1];
   logic [PAD_W-1:0] dq_ff   [DIV_STAGES+1];
   logic [1:0]       dr_ff   [DIV_STAGES+1];
   logic [BIN_W-1:0] draw_ff [DIV_STAGES+1];

   // detector
   logic             out_v;
   logic [IDX_W-1:0] out_idx;
   logic [BIN_W-1:0] out_val;
   logic [BIN_W-1:0] det_d1_ff, det_d2_ff;
   logic [1:0]       peaks_ff;
   logic             seen_ff, found_ff, done_ff;
   logic [IDX_W-1:0] vidx_ff;
   logic             peak_here, valley_here;

   // result register
   logic             rsp_valid_ff;
   logic [7:0]       rsp_thr_ff;
   status_type       rsp_status_ff;
   logic [PASS_W-1:0] rsp_passes_ff;
   logic             rsp_limit_ff;
   logic [IDX_W:0]   mid_sum;
   logic [IDX_W+7:0] mid_wide;
   logic [IDX_W+7:0] vidx_wide;
   logic [7:0]       thr_sel;

   for (genvar b = 0; b < 2; b++) begin : g_bank
      hmt_ram #(
         .WIDTH (BIN_W),
         .DEPTH (BIN_COUNT)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_addr[b]),
         .wr_data (wr_data[b]),
         .rd_addr (rd_addr),
         .rd_data (rd_data[b])
      );

      always_comb begin
         wr_en[b]   = 1'b0;
         wr_addr[b] = clr_idx_ff;
         wr_data[b] = '0;
         priority if (cmd.clear) begin
            wr_en[b] = 1'b1;
         end else if (cmd.acc_write && (cmd.src_bank == 1'(b))) begin
            wr_en[b]   = 1'b1;
            wr_addr[b] = px_idx_ff;
            wr_data[b] = acc_val;
         end else if (out_v && smooth_mode_ff && (cmd.src_bank != 1'(b))) begin
            wr_en[b]   = 1'b1;
            wr_addr[b] = out_idx;
            wr_data[b] = out_val;
         end else begin
            wr_en[b] = 1'b0;
         end
      end
   end

   assign rdata = rd_data[cmd.src_bank];

   // levels beyond the bins land in the top bin
   assign req_wide = (IDX_W+8)'(req_tdata);
   assign req_idx  = (req_wide >= (IDX_W+8)'(BIN_COUNT)) ? LAST_IDX : req_wide[IDX_W-1:0];
   assign acc_val  = (rdata >= MAX_BIN - ONE_COUNT) ? MAX_BIN : rdata + ONE_COUNT;

   assign stream_addr = (rd_idx_ff > (IDX_W+1)'(BIN_COUNT - 1)) ? LAST_IDX
                                                                 : rd_idx_ff[IDX_W-1:0];
   assign rd_addr = running_ff ? stream_addr : req_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         levels_ff  <= '0;
      end else begin
         clr_idx_ff <= cmd.clear ? clr_idx_ff + 1'b1 : '0;
         if (cmd.clear) begin
            levels_ff <= '0;
         end else if (cmd.acc_write && (rdata == '0) && (levels_ff != 2'd3)) begin
            levels_ff <= levels_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_take) begin
         px_idx_ff <= req_idx;
         if (levels_ff == 2'd0) begin
            lo_ff <= req_idx;
            hi_ff <= req_idx;
         end else begin
            lo_ff <= (req_idx < lo_ff) ? req_idx : lo_ff;
            hi_ff <= (req_idx > hi_ff) ? req_idx : hi_ff;
         end
      end
   end

   // one read past the end replicates the top edge bin
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         rd_idx_ff      <= '0;
         smooth_mode_ff <= 1'b0;
         s1_v_ff        <= 1'b0;
      end else begin
         s1_v_ff <= running_ff;
         if (cmd.stream_start) begin
            running_ff     <= 1'b1;
            rd_idx_ff      <= '0;
            smooth_mode_ff <= cmd.stream_smooth;
         end else if (running_ff) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
            if (rd_idx_ff == (IDX_W+1)'(BIN_COUNT)) begin
               running_ff <= 1'b0;
            end
         end
      end
   end

   assign s1_idx_m1 = s1_idx_ff - 1'b1;
   assign win_sum   = SUM_W'(win_pp_ff) + SUM_W'(win_p_ff) + SUM_W'(rdata);

   always_ff @(posedge clock) begin
      s1_idx_ff <= rd_idx_ff;
      if (s1_v_ff) begin
         // the bottom edge bin stands in for its missing left neighbour
         win_pp_ff <= (s1_idx_ff == '0) ? rdata : win_p_ff;
         win_p_ff  <= rdata;
      end
      didx_ff[0] <= s1_idx_m1[IDX_W-1:0];
      dx_ff[0]   <= PAD_W'(win_sum);
      dq_ff[0]   <= '0;
      dr_ff[0]   <= '0;
      draw_ff[0] <= win_p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= s1_v_ff && (s1_idx_ff != '0);
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [17:0] slice_res;

      assign slice_res = div3_slice(dr_ff[k], dx_ff[k][PAD_W-1-16*k -: 16]);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         didx_ff[k+1] <= didx_ff[k];
         dx_ff[k+1]   <= dx_ff[k];
         dr_ff[k+1]   <= slice_res[17:16];
         dq_ff[k+1]   <= dq_ff[k] | (PAD_W'(slice_res[15:0]) << (PAD_W - 16 - 16*k));
         draw_ff[k+1] <= draw_ff[k];
      end
   end

   assign out_v   = dv_ff[DIV_STAGES];
   assign out_idx = didx_ff[DIV_STAGES];
   assign out_val = smooth_mode_ff ? dq_ff[DIV_STAGES][BIN_W-1:0] : draw_ff[DIV_STAGES];

   assign peak_here   = (det_d2_ff < det_d1_ff) && (det_d1_ff > out_val);
   assign valley_here = (det_d2_ff > det_d1_ff) && (det_d1_ff < out_val);

   always_ff @(posedge clock) begin
      if (out_v) begin
         det_d2_ff <= det_d1_ff;
         det_d1_ff <= out_val;
      end
      if (out_v && (out_idx >= IDX_W'(2)) && valley_here && seen_ff && !found_ff) begin
         vidx_ff <= out_idx - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 1'b0;
         peaks_ff <= '0;
         seen_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         done_ff <= out_v && (out_idx == LAST_IDX);
         if (out_v) begin
            if (out_idx == '0) begin
               peaks_ff <= '0;
               seen_ff  <= 1'b0;
               found_ff <= 1'b0;
            end else if (out_idx >= IDX_W'(2)) begin
               if (peak_here) begin
                  seen_ff <= 1'b1;
                  if (peaks_ff != 2'd3) begin
                     peaks_ff <= peaks_ff + 1'b1;
                  end
               end
               // keep only the first valley after a peak
               if (valley_here && seen_ff) begin
                  found_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign mid_sum   = (IDX_W+1)'(lo_ff) + (IDX_W+1)'(hi_ff);
   assign mid_wide  = (IDX_W+8)'(mid_sum[IDX_W:1]);
   assign vidx_wide = (IDX_W+8)'(vidx_ff);

   always_comb begin
      unique case (cmd.rsp_status)
         STATUS_VALLEY:   thr_sel = vidx_wide[7:0];
         STATUS_MIDPOINT: thr_sel = mid_wide[7:0];
         STATUS_SINGLE:   thr_sel = 8'd0;
         STATUS_NONE:     thr_sel = 8'd0;
         default:         thr_sel = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_thr_ff    <= thr_sel;
         rsp_status_ff <= cmd.rsp_status;
         rsp_passes_ff <= cmd.rsp_passes;
         rsp_limit_ff  <= cmd.rsp_limit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_passes_ff, rsp_thr_ff};
   assign rsp_tuser  = {rsp_limit_ff, rsp_status_ff};

   always_comb begin
      stat.clear_done   = cmd.clear && (clr_idx_ff == LAST_IDX);
      stat.stream_done  = done_ff;
      stat.rsp_free     = !rsp_valid_ff || rsp_tready;
      stat.levels       = levels_ff;
      stat.peaks        = peaks_ff;
      stat.valley_found = found_ff;
   end

`ifndef ASSERT_OFF
   a_take_then_write: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_take |=> cmd.acc_write)
      else $error("pixel transfer not followed by its bin update");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over one not yet taken");

   a_clear_while_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !running_ff)
      else $error("bank clear during a bin stream");
`endif

endmodule

@@ sv/histogram_minimum_threshold.sv @@
// A pixel transfer reads its bin, then updates it; no new pixel is taken until then.
// After the last pixel, a peak scan, each smoothing pass and the valley scan each stream
// every bin through the single read port of the bin memory; at most two occupied levels
// give a result with no scan. After each result, and after reset, both banks are cleared
// with req_tready low. Reset is synchronous, active high; limit resets to 1000.
`timescale 1ns / 1ps

module histogram_minimum_threshold
   import hmt_pkg::*;
#(
   parameter int BIN_COUNT  = BIN_COUNT_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] gray_level
   input  logic               req_tlast,   // last_pixel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // [7:0] threshold, [20:8] passes_used
   output logic [2:0]         rsp_tuser,   // [1:0] status, [2] reached_limit
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data     // max_smoothing_passes
);

   hmt_cmd_type  cmd;
   hmt_stat_type stat;

   hmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   hmt_datapath #(
      .BIN_COUNT  (BIN_COUNT),
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
